/* hw/rtl/utfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utfc_pkg
// Shared types and constants for the UDP tunnel header flow classifier.
// ----------------------------------------------------------------------------
package utfc_pkg;

	localparam logic [15:0] HDR_MIN_LEN  = 16'd16;
	localparam logic [7:0]  HDR_MAGIC    = 8'h4c;
	localparam logic [7:0]  HDR_MAX_TYPE = 8'h01;

	localparam logic [1:0] VERDICT_PENDING  = 2'd0;
	localparam logic [1:0] VERDICT_EXCLUDED = 2'd1;
	localparam logic [1:0] VERDICT_DETECTED = 2'd2;

	typedef struct packed {
		logic        new_flow;
		logic [15:0] payload_length;
		logic [7:0]  magic_byte;
		logic [7:0]  type_byte;
		logic [15:0] first_msg_len;
		logic [15:0] conn_id;
		logic [31:0] session_token;
		logic        direction;
	} pkt_hdr_t;

	// control from the top level into the flow tracker
	typedef struct packed {
		logic step;
		logic hdr_ok;
	} trk_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/utfc_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utfc_in_if
// Packet header channel: one item per packet, valid/ready handshake.
// ----------------------------------------------------------------------------
interface utfc_in_if;
	logic        valid;
	logic        ready;
	logic        new_flow;
	logic [15:0] payload_length;
	logic [7:0]  magic_byte;
	logic [7:0]  type_byte;
	logic [15:0] first_msg_len;
	logic [15:0] conn_id;
	logic [31:0] session_token;
	logic        direction;

	modport source (
		output valid, new_flow, payload_length, magic_byte, type_byte,
		       first_msg_len, conn_id, session_token, direction,
		input  ready
	);
	modport sink (
		input  valid, new_flow, payload_length, magic_byte, type_byte,
		       first_msg_len, conn_id, session_token, direction,
		output ready
	);
endinterface
`default_nettype wire

/* hw/rtl/utfc_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utfc_out_if
// Verdict channel: one item per packet, valid/ready handshake.
// ----------------------------------------------------------------------------
interface utfc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface
`default_nettype wire

/* hw/rtl/udp_tunnel_header_flow_classifier.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// udp_tunnel_header_flow_classifier
// Classifies one UDP flow from per-packet tunnel header fields.
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   packet header fields, new_flow, direction
//   out_ch    out  valid/ready   verdict (0 pending, 1 excluded, 2 detected)
//
// One item per cycle sustained while the output does not stall. An item taken
// sits in the input register; its verdict is then loaded into the result
// register, from which it leaves on the output channel.
// Reset clears both valid flags and the flow stage; no clearing pass.
// An output stall holds the result register; the input register still takes
// an item while the result waits, so ready drops only when both are full.
// ----------------------------------------------------------------------------
module udp_tunnel_header_flow_classifier
	import utfc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	utfc_in_if.sink       in_ch,
	utfc_out_if.source    out_ch
);

	pkt_hdr_t   hdr_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic [1:0] verdict_q;
	logic       advance;
	logic       hdr_ok;
	logic [1:0] verdict;
	trk_ctrl_t  ctrl;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			hdr_s1.new_flow       <= in_ch.new_flow;
			hdr_s1.payload_length <= in_ch.payload_length;
			hdr_s1.magic_byte     <= in_ch.magic_byte;
			hdr_s1.type_byte      <= in_ch.type_byte;
			hdr_s1.first_msg_len  <= in_ch.first_msg_len;
			hdr_s1.conn_id        <= in_ch.conn_id;
			hdr_s1.session_token  <= in_ch.session_token;
			hdr_s1.direction      <= in_ch.direction;
		end
	end

	utfc_hdr_check u_hdr_check (
		.hdr    (hdr_s1),
		.hdr_ok (hdr_ok)
	);

	assign ctrl.step   = advance;
	assign ctrl.hdr_ok = hdr_ok;

	utfc_flow_track u_flow_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.hdr     (hdr_s1),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_q <= verdict;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.verdict = verdict_q;

endmodule
`default_nettype wire

/* hw/rtl/utfc_hdr_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utfc_hdr_check
// Fixed 16-byte header sanity checks: length, magic, type, first message length.
// ----------------------------------------------------------------------------
module utfc_hdr_check
	import utfc_pkg::*;
(
	input  pkt_hdr_t hdr,
	output logic     hdr_ok
);

	logic len_ok;
	logic magic_ok;
	logic type_ok;
	logic msg_ok;

	assign len_ok   = hdr.payload_length >= HDR_MIN_LEN;
	assign magic_ok = hdr.magic_byte == HDR_MAGIC;
	assign type_ok  = hdr.type_byte <= HDR_MAX_TYPE;
	assign msg_ok   = (hdr.first_msg_len >= HDR_MIN_LEN) &&
	                  (hdr.first_msg_len <= hdr.payload_length);
	assign hdr_ok   = len_ok && magic_ok && type_ok && msg_ok;

endmodule
`default_nettype wire

/* hw/rtl/utfc_flow_track.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utfc_flow_track
// Per-flow stage and stored id/token pairs; produces the verdict of one item.
// ----------------------------------------------------------------------------
module utfc_flow_track
	import utfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  trk_ctrl_t  ctrl,
	input  pkt_hdr_t   hdr,
	output logic [1:0] verdict
);

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_HAVE0    = 3'd1,
		ST_HAVE1    = 3'd2,
		ST_BOTH     = 3'd3,
		ST_EXCLUDED = 3'd4,
		ST_DETECTED = 3'd5
	} stage_t;

	stage_t      stage_q;
	stage_t      stage_eff;
	stage_t      stage_nxt;
	logic [15:0] ids_q  [2];
	logic [31:0] toks_q [2];
	logic        wr_en;
	logic        other;
	logic        match_own;
	logic        clash_other;

	// new_flow restarts the flow before this item is looked at
	assign stage_eff = hdr.new_flow ? ST_IDLE : stage_q;
	assign other     = (stage_eff == ST_HAVE1);

	assign match_own   = (hdr.conn_id == ids_q[hdr.direction]) &&
	                     (hdr.session_token == toks_q[hdr.direction]);
	assign clash_other = (hdr.conn_id == ids_q[other]) ||
	                     (hdr.session_token == toks_q[other]);

	always_comb begin
		stage_nxt = stage_eff;
		verdict   = VERDICT_PENDING;
		wr_en     = 1'b0;
		unique case (stage_eff)
			ST_DETECTED: begin
				verdict = VERDICT_DETECTED;
			end
			ST_IDLE: begin
				if (!ctrl.hdr_ok) begin
					stage_nxt = ST_EXCLUDED;
					verdict   = VERDICT_EXCLUDED;
				end else begin
					wr_en     = 1'b1;
					stage_nxt = hdr.direction ? ST_HAVE1 : ST_HAVE0;
				end
			end
			ST_HAVE0, ST_HAVE1: begin
				if (!ctrl.hdr_ok ||
				    ((hdr.direction == other) && !match_own) ||
				    ((hdr.direction != other) && clash_other)) begin
					stage_nxt = ST_EXCLUDED;
					verdict   = VERDICT_EXCLUDED;
				end else if (hdr.direction != other) begin
					wr_en     = 1'b1;
					stage_nxt = ST_BOTH;
				end
			end
			ST_BOTH: begin
				if (!ctrl.hdr_ok || !match_own) begin
					stage_nxt = ST_EXCLUDED;
					verdict   = VERDICT_EXCLUDED;
				end else begin
					stage_nxt = ST_DETECTED;
					verdict   = VERDICT_DETECTED;
				end
			end
			default: begin
				// excluded, and the unused codes
				stage_nxt = ST_EXCLUDED;
				verdict   = VERDICT_EXCLUDED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
		end else if (ctrl.step) begin
			stage_q <= stage_nxt;
		end
	end

	// pairs are only read after their direction was written in this flow
	always_ff @(posedge clk) begin
		if (ctrl.step && wr_en) begin
			ids_q[hdr.direction]  <= hdr.conn_id;
			toks_q[hdr.direction] <= hdr.session_token;
		end
	end

`ifndef SYNTHESIS
	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q <= ST_DETECTED)
		else $error("flow stage holds an unused code");

	a_bad_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step && !ctrl.hdr_ok |-> verdict != VERDICT_PENDING)
		else $error("failed header gave pending verdict");

	a_det_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step && verdict == VERDICT_DETECTED |=> stage_q == ST_DETECTED)
		else $error("detected verdict did not stick");

	a_exc_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step && !hdr.new_flow && stage_q == ST_EXCLUDED
		|-> verdict == VERDICT_EXCLUDED)
		else $error("excluded flow left its terminal stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.step |=> $stable(stage_q))
		else $error("flow stage moved without an item");
`endif

endmodule
`default_nettype wire
